// File: design/dprfe_pkg.sv
`timescale 1ns / 1ps

package dprfe_pkg;

    localparam int SYSTEM_CODE_W = 4;
    localparam int UNIT_MASK_W   = 10;
    localparam int ADDR_W        = SYSTEM_CODE_W + UNIT_MASK_W;
    localparam int DATA_W        = 6;
    localparam int LEVEL_W       = 8;
    localparam int QUANT_W       = 4;
    localparam int SYM_W         = 2;
    localparam int CFG_INDEX_W   = 2;
    localparam int CFG_DATA_W    = 10;

    localparam int SEQ_LEN = ADDR_W + 2 + DATA_W + 2;
    localparam int IDX_W   = $clog2(SEQ_LEN);

    localparam logic [CFG_INDEX_W-1:0] REG_SYSTEM_CODE = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_UNIT_MASK   = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_SMOOTH_FADE = 2'd2;

    localparam logic [SYM_W-1:0] SYM_S    = 2'd0;
    localparam logic [SYM_W-1:0] SYM_T    = 2'd1;
    localparam logic [SYM_W-1:0] SYM_MARK = 2'd2;
    localparam logic [SYM_W-1:0] SYM_END  = 2'd3;

    localparam logic [DATA_W-1:0] FADE_SMOOTH  = 6'h30;
    localparam logic [DATA_W-1:0] FADE_INSTANT = 6'h10;

    typedef struct packed {
        logic [SYSTEM_CODE_W-1:0] system_code;
        logic [UNIT_MASK_W-1:0]   unit_mask;
        logic                     smooth_fade;
    } cfg_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_PRE,
        ST_BITS,
        ST_END
    } ser_state_t;

endpackage

// File: design/dprfe_frame_build.sv
`timescale 1ns / 1ps

module dprfe_frame_build (
    input  logic [dprfe_pkg::LEVEL_W-1:0] level,
    input  dprfe_pkg::cfg_t               cfg,
    output logic [dprfe_pkg::SEQ_LEN-1:0] frame_bits
);

    localparam logic [dprfe_pkg::LEVEL_W-1:0] LEVEL_OFF_MAX  = 8'd12;
    localparam logic [dprfe_pkg::LEVEL_W-1:0] LEVEL_FULL_MIN = 8'd237;
    localparam logic [dprfe_pkg::QUANT_W-1:0] QUANT_OFF      = 4'd10;
    localparam logic [dprfe_pkg::QUANT_W-1:0] QUANT_FULL     = 4'd0;
    localparam int STEP_BASE = 13;
    localparam int STEP_SIZE = 25;
    localparam int STEPS     = 8;

    localparam logic [dprfe_pkg::ADDR_W-1:0] ADDR_ODD_MASK  = 14'h2AAA;
    localparam logic [dprfe_pkg::ADDR_W-1:0] ADDR_EVEN_MASK = 14'h1555;
    localparam logic [dprfe_pkg::DATA_W-1:0] DATA_EVEN_MASK = 6'h15;
    localparam logic [dprfe_pkg::DATA_W-1:0] DATA_ODD_MASK  = 6'h2A;

    function automatic logic [dprfe_pkg::QUANT_W-1:0] quantize(
        input logic [dprfe_pkg::LEVEL_W-1:0] l
    );
        logic [dprfe_pkg::QUANT_W-1:0] q;
        logic [dprfe_pkg::LEVEL_W-1:0] thr;
        q = 4'd1;
        for (int k = 1; k <= STEPS; k++) begin
            thr = dprfe_pkg::LEVEL_W'(STEP_BASE + STEP_SIZE * k);
            if (l >= thr) begin
                q = q + 4'd1;
            end
        end
        if (l <= LEVEL_OFF_MAX) begin
            q = QUANT_OFF;
        end else if (l > LEVEL_FULL_MIN) begin
            q = QUANT_FULL;
        end
        return q;
    endfunction

    logic [dprfe_pkg::ADDR_W-1:0] addr;
    logic [dprfe_pkg::DATA_W-1:0] data;
    logic [dprfe_pkg::DATA_W-1:0] fade;

    assign addr = {cfg.system_code, cfg.unit_mask};
    assign fade = cfg.smooth_fade ? dprfe_pkg::FADE_SMOOTH : dprfe_pkg::FADE_INSTANT;
    assign data = {2'b00, quantize(level)} | fade;

    // order of transmission: address msb first, parity, data lsb first, parity
    always_comb begin
        for (int i = 0; i < dprfe_pkg::ADDR_W; i++) begin
            frame_bits[i] = addr[dprfe_pkg::ADDR_W-1-i];
        end
        frame_bits[dprfe_pkg::ADDR_W]     = ~^(addr & ADDR_ODD_MASK);
        frame_bits[dprfe_pkg::ADDR_W + 1] = ~^(addr & ADDR_EVEN_MASK);
        for (int i = 0; i < dprfe_pkg::DATA_W; i++) begin
            frame_bits[dprfe_pkg::ADDR_W + 2 + i] = data[i];
        end
        frame_bits[dprfe_pkg::SEQ_LEN-2] = ~^(data & DATA_EVEN_MASK);
        frame_bits[dprfe_pkg::SEQ_LEN-1] = ~^(data & DATA_ODD_MASK);
    end

endmodule

// File: design/dprfe_serializer.sv
`timescale 1ns / 1ps

module dprfe_serializer (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            load_valid,
    output logic                            load_take,
    input  logic [dprfe_pkg::SEQ_LEN-1:0]   frame_bits,
    input  logic                            out_ready,
    output logic                            out_valid,
    output logic [dprfe_pkg::SYM_W-1:0]     out_symbol,
    output logic                            out_last
);

    localparam logic [2:0] PRE_LAST = 3'd7;
    localparam logic [dprfe_pkg::IDX_W-1:0] IDX_LAST = dprfe_pkg::IDX_W'(dprfe_pkg::SEQ_LEN - 1);

    dprfe_pkg::ser_state_t state_reg, state_next;

    logic [dprfe_pkg::SEQ_LEN-1:0] frame_reg;
    logic [2:0]                    pre_cnt_reg;
    logic [dprfe_pkg::IDX_W-1:0]   bit_idx_reg;
    logic                          half_reg;
    logic                          out_valid_reg;
    logic [dprfe_pkg::SYM_W-1:0]   symbol_reg;
    logic                          last_reg;

    logic                          out_free;
    logic                          emit;
    logic                          cur_bit;
    logic                          bit_done;
    logic [dprfe_pkg::SYM_W-1:0]   sym_next;

    assign out_free  = !out_valid_reg || out_ready;
    assign emit      = out_free && (state_reg != dprfe_pkg::ST_IDLE);
    assign cur_bit   = frame_reg[bit_idx_reg];
    assign bit_done  = !cur_bit || half_reg;
    assign load_take = load_valid && ((state_reg == dprfe_pkg::ST_IDLE) ||
                       ((state_reg == dprfe_pkg::ST_END) && out_free));

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            dprfe_pkg::ST_IDLE: begin
                if (load_take) state_next = dprfe_pkg::ST_PRE;
            end
            dprfe_pkg::ST_PRE: begin
                if (out_free && pre_cnt_reg == PRE_LAST) state_next = dprfe_pkg::ST_BITS;
            end
            dprfe_pkg::ST_BITS: begin
                if (out_free && bit_done && bit_idx_reg == IDX_LAST) begin
                    state_next = dprfe_pkg::ST_END;
                end
            end
            dprfe_pkg::ST_END: begin
                if (out_free) begin
                    state_next = load_take ? dprfe_pkg::ST_PRE : dprfe_pkg::ST_IDLE;
                end
            end
            default: state_next = dprfe_pkg::ST_IDLE;
        endcase
    end

    always_comb begin
        sym_next = dprfe_pkg::SYM_T;
        case (state_reg)
            dprfe_pkg::ST_PRE: begin
                if (pre_cnt_reg == 3'd0) sym_next = dprfe_pkg::SYM_S;
                else if (pre_cnt_reg == PRE_LAST) sym_next = dprfe_pkg::SYM_MARK;
                else sym_next = dprfe_pkg::SYM_T;
            end
            dprfe_pkg::ST_BITS: begin
                sym_next = cur_bit ? dprfe_pkg::SYM_T : dprfe_pkg::SYM_MARK;
            end
            dprfe_pkg::ST_END: sym_next = dprfe_pkg::SYM_END;
            default: sym_next = dprfe_pkg::SYM_T;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= dprfe_pkg::ST_IDLE;
            out_valid_reg <= 1'b0;
            pre_cnt_reg   <= 3'd0;
            bit_idx_reg   <= '0;
            half_reg      <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (out_free) begin
                out_valid_reg <= emit;
            end
            if (load_take) begin
                pre_cnt_reg <= 3'd0;
                bit_idx_reg <= '0;
                half_reg    <= 1'b0;
            end else if (emit) begin
                if (state_reg == dprfe_pkg::ST_PRE) begin
                    pre_cnt_reg <= pre_cnt_reg + 3'd1;
                end
                if (state_reg == dprfe_pkg::ST_BITS) begin
                    half_reg <= !bit_done;
                    if (bit_done && bit_idx_reg != IDX_LAST) begin
                        bit_idx_reg <= bit_idx_reg + 1'b1;
                    end
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (load_take) begin
            frame_reg <= frame_bits;
        end
        if (out_free) begin
            symbol_reg <= sym_next;
            last_reg   <= (state_reg == dprfe_pkg::ST_END);
        end
    end

    assign out_valid  = out_valid_reg;
    assign out_symbol = symbol_reg;
    assign out_last   = last_reg;

    a_last_is_end: assert property (@(posedge aclk) disable iff (!aresetn)
        out_valid_reg |-> (last_reg == (symbol_reg == dprfe_pkg::SYM_END)))
        else $error("last flag and end symbol disagree");

    a_half_on_one: assert property (@(posedge aclk) disable iff (!aresetn)
        half_reg |-> (state_reg == dprfe_pkg::ST_BITS) && cur_bit)
        else $error("second T half outside a one bit");

    a_end_after_bits: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == dprfe_pkg::ST_END) |-> $past(state_reg) == dprfe_pkg::ST_END ||
        $past(state_reg) == dprfe_pkg::ST_BITS)
        else $error("end symbol not preceded by frame bits");

    a_load_when_free: assert property (@(posedge aclk) disable iff (!aresetn)
        load_take |-> (state_reg == dprfe_pkg::ST_IDLE) || (state_reg == dprfe_pkg::ST_END))
        else $error("frame loaded in the middle of a frame");

endmodule

// File: design/dimmer_rf_pulse_frame_encoder_core.sv
`timescale 1ns / 1ps

// channel  | direction | handshake                  | payload
// ---------+-----------+----------------------------+------------------------------
// s_       | in        | s_tvalid / s_tready        | s_tdata[7:0] level
// m_       | out       | m_tvalid / m_tready        | m_tdata[1:0] symbol, m_tlast
// cfg_     | in        | cfg_valid / cfg_ready      | cfg_index, cfg_data
//
// One brightness beat yields one frame of 37 to 53 symbol beats, one per cycle while
// m_tready is high; the symbol sequencer that walks the frame sets this rate.
// A beat waits in the input register until the sequencer is idle or emits the end
// symbol of the previous frame, so frames run gap-free; from an idle sequencer the
// beat passes the frame register, then the output register, before a symbol is valid.
// Reset is synchronous, active low, and clears the control state and configuration.
// A stall on m_tready holds the sequencer and the output beat in place.

module dimmer_rf_pulse_frame_encoder_core (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,     // [7:0] level
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata,     // [1:0] symbol, [7:2] zero
    output logic       m_tlast,
    input  logic       cfg_valid,
    output logic       cfg_ready,
    input  logic [dprfe_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [dprfe_pkg::CFG_DATA_W-1:0]  cfg_data
);

    dprfe_pkg::cfg_t cfg_reg;

    logic [dprfe_pkg::LEVEL_W-1:0] level_reg;
    logic                          hold_valid_reg;
    logic                          load_take;
    logic [dprfe_pkg::SEQ_LEN-1:0] frame_bits;
    logic [dprfe_pkg::SYM_W-1:0]   symbol;

    assign cfg_ready = 1'b1;
    assign s_tready  = !hold_valid_reg || load_take;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg        <= '0;
            hold_valid_reg <= 1'b0;
        end else begin
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    dprfe_pkg::REG_SYSTEM_CODE:
                        cfg_reg.system_code <= cfg_data[dprfe_pkg::SYSTEM_CODE_W-1:0];
                    dprfe_pkg::REG_UNIT_MASK:
                        cfg_reg.unit_mask <= cfg_data[dprfe_pkg::UNIT_MASK_W-1:0];
                    dprfe_pkg::REG_SMOOTH_FADE:
                        cfg_reg.smooth_fade <= cfg_data[0];
                    default: ;
                endcase
            end
            if (s_tvalid && s_tready) begin
                hold_valid_reg <= 1'b1;
            end else if (load_take) begin
                hold_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            level_reg <= s_tdata;
        end
    end

    dprfe_frame_build u_build (
        .level      (level_reg),
        .cfg        (cfg_reg),
        .frame_bits (frame_bits)
    );

    dprfe_serializer u_ser (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .load_valid (hold_valid_reg),
        .load_take  (load_take),
        .frame_bits (frame_bits),
        .out_ready  (m_tready),
        .out_valid  (m_tvalid),
        .out_symbol (symbol),
        .out_last   (m_tlast)
    );

    assign m_tdata = {6'b000000, symbol};

endmodule
